// ===== src/dtoi_pkg.sv =====
//------------------------------------------------------------------------------
// dtoi_pkg - shared definitions for the decimal text to int64 unit
// Widths, character codes and the parser phase type.
//------------------------------------------------------------------------------
`default_nettype none

package dtoi_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned ValueW = 64;
	localparam int unsigned DigitW = 4;

	localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
	localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
	localparam logic [ByteW-1:0] CH_ONE   = 8'h31;
	localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

	// Parser phase; the fourth code is unused and behaves as PH_DIGITS
	typedef enum logic [1:0] {
		PH_FIRST       = 2'd0,
		PH_AFTER_MINUS = 2'd1,
		PH_DIGITS      = 2'd2
	} phase_t;

endpackage

`default_nettype wire

// ===== src/decimal_text_to_int64_unit.sv =====
//------------------------------------------------------------------------------
// decimal_text_to_int64_unit - strict ASCII decimal to signed 64-bit parser
// Takes one character per request and gives one result per string.
//------------------------------------------------------------------------------
// A string arrives one ASCII byte per request, last_byte marking its final
// character. Accepted syntax: an optional leading '-', then a digit '1'..'9'
// followed only by digits, or a lone '0' (so "-0" and "01" are rejected).
// No '+', no spaces. Overflow of the unsigned 64-bit accumulation, or a final
// magnitude outside the signed 64-bit range, fails the string; after a failure
// further bytes are ignored up to the last one. Only the last byte of a
// string produces a result: parse_ok and parsed_value (0 when parse_ok is 0).
// Throughput is one byte per clock while no last byte is held back: the
// multiply-by-ten-and-add of the running magnitude is a single shift-add with
// its overflow taken from the carry bits, done combinationally between the
// input register and the parser state. For a last byte the range check and
// negation follow in the same cycle, straight into the result register. Bytes
// other than the last keep flowing while a result waits on out_stall; only a
// last byte queues behind an undelivered result.
//------------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_int64_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dtoi_pkg::ByteW-1:0]    text_byte,
	input  wire logic                          last_byte,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               parse_ok,
	output logic signed [dtoi_pkg::ValueW-1:0] parsed_value
);

	import dtoi_pkg::*;

	localparam int unsigned AccW = ValueW + 4;

	// input register
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;

	// parser state
	logic [ValueW-1:0] mag_q;
	logic              neg_q;
	phase_t            phase_q;
	logic              lone_zero_q;
	logic              failed_q;

	// result register
	logic              out_valid_q;
	logic              ok_q;
	logic [ValueW-1:0] value_q;

	// flow control
	logic out_free, s1_move, s1_free;

	// next-state logic
	logic [ValueW-1:0] mag_n;
	logic              neg_n;
	phase_t            phase_n;
	logic              lone_zero_n;
	logic              failed_n;
	logic [AccW-1:0]   acc;
	logic [DigitW-1:0] digit;
	logic              is_digit, is_nonzero_digit;

	// final checks
	logic              in_range;
	logic              ok_n;
	logic [ValueW-1:0] value_n;

	//--------------------------------------------------------------------------
	// Handshake: each stage moves when the one ahead is empty or moving.
	// A non-last byte only updates the parser state and never needs the
	// result register.
	//--------------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && (!last_s1 || out_free);
	assign s1_free  = !valid_s1 || s1_move;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	//--------------------------------------------------------------------------
	// Character classification and the x10 + digit step.
	// mag*10 + d = (mag << 3) + (mag << 1) + d; any carry above bit 63 is an
	// overflow, covering both the multiply and the add checks at once.
	//--------------------------------------------------------------------------
	assign digit            = byte_s1[DigitW-1:0];
	assign is_digit         = byte_s1 inside {[CH_ZERO:CH_NINE]};
	assign is_nonzero_digit = byte_s1 inside {[CH_ONE:CH_NINE]};
	assign acc = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
		+ {{(AccW-DigitW){1'b0}}, digit};

	always_comb begin
		mag_n       = mag_q;
		neg_n       = neg_q;
		phase_n     = phase_q;
		lone_zero_n = lone_zero_q;
		failed_n    = failed_q;
		if (!failed_q) begin
			case (phase_q)
				PH_FIRST: begin
					if (byte_s1 == CH_MINUS) begin
						neg_n   = 1'b1;
						phase_n = PH_AFTER_MINUS;
					end else if (is_nonzero_digit) begin
						mag_n   = {{(ValueW-DigitW){1'b0}}, digit};
						phase_n = PH_DIGITS;
					end else if (byte_s1 == CH_ZERO) begin
						lone_zero_n = 1'b1;
						mag_n       = '0;
						phase_n     = PH_DIGITS;
					end else begin
						failed_n = 1'b1;
					end
				end
				PH_AFTER_MINUS: begin
					if (is_nonzero_digit) begin
						mag_n   = {{(ValueW-DigitW){1'b0}}, digit};
						phase_n = PH_DIGITS;
					end else begin
						failed_n = 1'b1;
					end
				end
				default: begin
					if (lone_zero_q || !is_digit || (acc[AccW-1:ValueW] != '0)) begin
						failed_n = 1'b1;
					end else begin
						mag_n = acc[ValueW-1:0];
					end
				end
			endcase
		end
	end

	// State clears after the last byte of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q       <= '0;
			neg_q       <= 1'b0;
			phase_q     <= PH_FIRST;
			lone_zero_q <= 1'b0;
			failed_q    <= 1'b0;
		end else if (s1_move) begin
			if (last_s1) begin
				mag_q       <= '0;
				neg_q       <= 1'b0;
				phase_q     <= PH_FIRST;
				lone_zero_q <= 1'b0;
				failed_q    <= 1'b0;
			end else begin
				mag_q       <= mag_n;
				neg_q       <= neg_n;
				phase_q     <= phase_n;
				lone_zero_q <= lone_zero_n;
				failed_q    <= failed_n;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Final value of a finished string.
	// Negative side admits exactly 2^63; positive side needs bit 63 clear.
	//--------------------------------------------------------------------------
	assign in_range = neg_n
		? (!mag_n[ValueW-1] || (mag_n[ValueW-2:0] == '0))
		: !mag_n[ValueW-1];
	assign value_n  = neg_n ? (~mag_n + {{(ValueW-1){1'b0}}, 1'b1}) : mag_n;
	assign ok_n     = !failed_n && (phase_n != PH_FIRST) && (phase_n != PH_AFTER_MINUS)
		&& in_range;

	//--------------------------------------------------------------------------
	// Result register
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_move && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_s1) begin
			ok_q    <= ok_n;
			value_q <= ok_n ? value_n : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign parse_ok     = ok_q;
	assign parsed_value = value_q;

endmodule

`default_nettype wire
